// File: sv/svc_susceptance_dispatch_macros.svh
// assertion macros shared by the compensator rtl
`ifndef SVC_SUSCEPTANCE_DISPATCH_MACROS_SVH
`define SVC_SUSCEPTANCE_DISPATCH_MACROS_SVH

// property checked on every clock edge outside reset
`define SVC_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition now implies property on the next edge
`define SVC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// File: sv/svc_pkg.sv
package svc_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_ENABLE  = 3'd0;
    localparam t_cfg_index CFG_VREF    = 3'd1;
    localparam t_cfg_index CFG_GAIN    = 3'd2;
    localparam t_cfg_index CFG_TMIN    = 3'd3;
    localparam t_cfg_index CFG_QMIN    = 3'd4;
    localparam t_cfg_index CFG_QMAX    = 3'd5;
    localparam t_cfg_index CFG_TABLE   = 3'd6;

    // register reset values
    localparam logic               ENABLE_RST = 1'b1;
    localparam logic        [14:0] VREF_RST   = 15'd16384;
    localparam logic        [15:0] GAIN_RST   = 16'd25600;
    localparam logic signed [15:0] TMIN_RST   = -16'sd4096;
    localparam logic signed [14:0] QMIN_RST   = -15'sd160;
    localparam logic signed [14:0] QMAX_RST   = 15'sd1600;
    localparam logic        [59:0] TABLE_RST  = 60'd115432922317169050;

    // susceptance limits floor(q * 256 / 100) for the reset q limits
    localparam logic signed [16:0] BMIN_RST   = -17'sd410;
    localparam logic signed [16:0] BMAX_RST   = 17'sd4096;

    // floor(y / 25) for signed y: bias to positive, reciprocal multiply, unbias
    localparam logic [21:0] LIM_BIAS      = 22'd1638400;
    localparam logic [22:0] DIV25_RECIP   = 23'd5368710;
    localparam int          DIV25_SHIFT   = 27;
    localparam logic [17:0] LIM_UNBIAS    = 18'd65536;

    // product scaling: total * v * v * 100 / 2^36
    localparam logic [6:0]  Q_SCALE       = 7'd100;
    localparam int          Q_SHIFT       = 36;
    localparam int          BREF_SHIFT    = 10;

endpackage

// File: sv/svc_susceptance_dispatch.sv
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------------------
// input     | i_in_valid / o_in_ready      | i_measured_voltage
// output    | o_out_valid / i_out_ready    | o_reactive_power, o_total_susceptance,
//           |                              | o_capacitor_susceptance,
//           |                              | o_reactor_susceptance, o_step_mask
// config    | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while i_out_ready holds; input to output passes
// registered stages a, b, one per capacitor step of the greedy fit, then r, p and o
// synchronous reset returns registers to defaults and loads the sorted default step table
// each stage holds while its successor is full and held, empty stages fill behind a stalled output
`include "svc_susceptance_dispatch_macros.svh"

module svc_susceptance_dispatch #(
    parameter int NUM_STEPS  = 5,
    parameter int STEP_WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  svc_pkg::t_cfg_index      i_cfg_index,
    input  logic [((NUM_STEPS*STEP_WIDTH > 16) ? NUM_STEPS*STEP_WIDTH : 16)-1:0] i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [14:0]              i_measured_voltage,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [14:0]       o_reactive_power,
    output logic signed [15:0]       o_total_susceptance,
    output logic [14:0]              o_capacitor_susceptance,
    output logic signed [15:0]       o_reactor_susceptance,
    output logic [4:0]               o_step_mask
);

    localparam int TABLE_W = NUM_STEPS * STEP_WIDTH;
    localparam int RANK_W  = $clog2(NUM_STEPS + 1);

    // pipeline stage positions
    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_R = ST_B + NUM_STEPS + 1;
    localparam int ST_P = ST_R + 1;
    localparam int ST_O = ST_P + 1;
    localparam int NSTG = ST_O + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                    r_en;
    logic [14:0]             r_vref;
    logic [15:0]             r_gain;
    logic signed [15:0]      r_tmin;
    logic signed [14:0]      r_qmin;
    logic signed [14:0]      r_qmax;
    logic signed [16:0]      r_bmin;
    logic signed [16:0]      r_bmax;
    logic [STEP_WIDTH-1:0]   r_sort_val [NUM_STEPS];
    logic [NUM_STEPS-1:0]    r_sort_oh  [NUM_STEPS];

    // step table sort: rank by descending value, ties to the lower index
    logic [TABLE_W-1:0]      sort_src;
    logic [STEP_WIDTH-1:0]   cand       [NUM_STEPS];
    logic [RANK_W-1:0]       rank       [NUM_STEPS];
    logic [STEP_WIDTH-1:0]   n_sort_val [NUM_STEPS];
    logic [NUM_STEPS-1:0]    n_sort_oh  [NUM_STEPS];

    always_comb begin
        sort_src = !i_rst_n ? svc_pkg::TABLE_RST[TABLE_W-1:0] : i_cfg_data[TABLE_W-1:0];
        for (int i = 0; i < NUM_STEPS; i++) begin
            cand[i] = sort_src[i*STEP_WIDTH +: STEP_WIDTH];
        end
        for (int i = 0; i < NUM_STEPS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < NUM_STEPS; j++) begin
                if (j != i && (cand[j] > cand[i] || (cand[j] == cand[i] && j < i))) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int k = 0; k < NUM_STEPS; k++) begin
            n_sort_val[k] = '0;
            n_sort_oh[k]  = '0;
            for (int i = 0; i < NUM_STEPS; i++) begin
                if (rank[i] == RANK_W'(k)) begin
                    n_sort_val[k]   = n_sort_val[k] | cand[i];
                    n_sort_oh[k][i] = 1'b1;
                end
            end
        end
    end

    // q limit to susceptance limit: floor(q * 64 / 25)
    logic signed [21:0] lim_scaled;
    logic [21:0]        lim_biased;
    logic [44:0]        lim_prod;
    logic [17:0]        lim_quot;
    logic [17:0]        lim_diff;
    logic signed [16:0] n_blim;

    always_comb begin
        lim_scaled = {i_cfg_data[14], i_cfg_data[14:0], 6'b0};
        lim_biased = lim_scaled + svc_pkg::LIM_BIAS;
        lim_prod   = 45'(lim_biased) * 45'(svc_pkg::DIV25_RECIP);
        lim_quot   = lim_prod[svc_pkg::DIV25_SHIFT +: 18];
        lim_diff   = lim_quot - svc_pkg::LIM_UNBIAS;
        n_blim     = lim_diff[16:0];
    end

    // reactor limit, a positive value counts as zero
    logic signed [15:0] n_tmin;
    assign n_tmin = i_cfg_data[15] ? i_cfg_data[15:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en       <= svc_pkg::ENABLE_RST;
            r_vref     <= svc_pkg::VREF_RST;
            r_gain     <= svc_pkg::GAIN_RST;
            r_tmin     <= svc_pkg::TMIN_RST;
            r_qmin     <= svc_pkg::QMIN_RST;
            r_qmax     <= svc_pkg::QMAX_RST;
            r_bmin     <= svc_pkg::BMIN_RST;
            r_bmax     <= svc_pkg::BMAX_RST;
            r_sort_val <= n_sort_val;
            r_sort_oh  <= n_sort_oh;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                svc_pkg::CFG_ENABLE: r_en   <= i_cfg_data[0];
                svc_pkg::CFG_VREF:   r_vref <= i_cfg_data[14:0];
                svc_pkg::CFG_GAIN:   r_gain <= i_cfg_data[15:0];
                svc_pkg::CFG_TMIN:   r_tmin <= n_tmin;
                svc_pkg::CFG_QMIN: begin
                    r_qmin <= i_cfg_data[14:0];
                    r_bmin <= n_blim;
                end
                svc_pkg::CFG_QMAX: begin
                    r_qmax <= i_cfg_data[14:0];
                    r_bmax <= n_blim;
                end
                svc_pkg::CFG_TABLE: begin
                    r_sort_val <= n_sort_val;
                    r_sort_oh  <= n_sort_oh;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid and ready chain
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   stage_rdy;
    logic [NSTG-1:0] stage_in_vld;
    logic [NSTG-1:0] stage_load;

    always_comb begin
        stage_rdy[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
        stage_in_vld[0] = i_in_valid;
        for (int k = 1; k < NSTG; k++) begin
            stage_in_vld[k] = r_vld[k-1];
        end
        stage_load = stage_in_vld & stage_rdy[NSTG-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= stage_in_vld[k];
                end
            end
        end
    end

    assign o_in_ready  = stage_rdy[0];
    assign o_out_valid = r_vld[ST_O];

    // ------------------------------------------------------------------
    // stage a: gain times voltage error, voltage squared
    // ------------------------------------------------------------------
    logic signed [15:0] err;
    logic signed [32:0] n_a_prod;
    logic [29:0]        n_a_vv;
    logic signed [32:0] r_a_prod;
    logic [29:0]        r_a_vv;

    always_comb begin
        err      = $signed({1'b0, r_vref}) - $signed({1'b0, i_measured_voltage});
        n_a_prod = $signed({1'b0, r_gain}) * err;
        n_a_vv   = 30'(i_measured_voltage) * 30'(i_measured_voltage);
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[ST_A]) begin
            r_a_prod <= n_a_prod;
            r_a_vv   <= n_a_vv;
        end
    end

    // ------------------------------------------------------------------
    // stage b: scale and clamp the reference, voltage squared times 100
    // element j of the greedy arrays is the output of stage ST_B + j
    // ------------------------------------------------------------------
    logic signed [16:0] r_g_bref [NUM_STEPS+1];
    logic [15:0]        r_g_need [NUM_STEPS+1];
    logic [36:0]        r_g_vv   [NUM_STEPS+1];
    logic [14:0]        r_g_cap  [NUM_STEPS+1];
    logic [NUM_STEPS-1:0] r_g_mask [NUM_STEPS+1];

    logic signed [22:0] bref_raw;
    logic signed [22:0] bref_hi;
    logic signed [16:0] n_b_bref;

    always_comb begin
        bref_raw = r_a_prod[32:svc_pkg::BREF_SHIFT];
        bref_hi  = (bref_raw > 23'(r_bmax)) ? 23'(r_bmax) : bref_raw;
        n_b_bref = (bref_hi < 23'(r_bmin)) ? r_bmin : bref_hi[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[ST_B]) begin
            r_g_bref[0] <= n_b_bref;
            r_g_need[0] <= n_b_bref[16] ? '0 : n_b_bref[15:0];
            r_g_vv[0]   <= 37'(r_a_vv) * 37'(svc_pkg::Q_SCALE);
            r_g_cap[0]  <= '0;
            r_g_mask[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // greedy fit: one capacitor step per stage, largest first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        logic [15:0] sum;
        logic        fit;

        assign sum = 16'(r_g_cap[k]) + 16'(r_sort_val[k]);
        assign fit = sum <= r_g_need[k];

        always_ff @(posedge i_clk) begin
            if (stage_load[ST_B+1+k]) begin
                r_g_bref[k+1] <= r_g_bref[k];
                r_g_need[k+1] <= r_g_need[k];
                r_g_vv[k+1]   <= r_g_vv[k];
                r_g_cap[k+1]  <= fit ? sum[14:0] : r_g_cap[k];
                r_g_mask[k+1] <= fit ? (r_g_mask[k] | r_sort_oh[k]) : r_g_mask[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage r: reactor takes the negative residual
    // ------------------------------------------------------------------
    logic signed [17:0] resid;
    logic signed [15:0] n_r_reac;
    logic signed [15:0] r_r_total;
    logic signed [15:0] r_r_reac;
    logic [14:0]        r_r_cap;
    logic [NUM_STEPS-1:0] r_r_mask;
    logic [36:0]        r_r_vv;

    always_comb begin
        resid = 18'(r_g_bref[NUM_STEPS]) - $signed({3'b0, r_g_cap[NUM_STEPS]});
        if (resid[17]) begin
            n_r_reac = (resid < 18'(r_tmin)) ? r_tmin : resid[15:0];
        end else begin
            n_r_reac = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[ST_R]) begin
            r_r_reac  <= n_r_reac;
            r_r_total <= 16'(r_g_cap[NUM_STEPS]) + n_r_reac;
            r_r_cap   <= r_g_cap[NUM_STEPS];
            r_r_mask  <= r_g_mask[NUM_STEPS];
            r_r_vv    <= r_g_vv[NUM_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // stage p: total susceptance times 100 v^2
    // ------------------------------------------------------------------
    logic signed [53:0]   r_p_prod;
    logic signed [15:0]   r_p_total;
    logic signed [15:0]   r_p_reac;
    logic [14:0]          r_p_cap;
    logic [NUM_STEPS-1:0] r_p_mask;

    always_ff @(posedge i_clk) begin
        if (stage_load[ST_P]) begin
            r_p_prod  <= r_r_total * $signed({1'b0, r_r_vv});
            r_p_total <= r_r_total;
            r_p_reac  <= r_r_reac;
            r_p_cap   <= r_r_cap;
            r_p_mask  <= r_r_mask;
        end
    end

    // ------------------------------------------------------------------
    // stage o: scale, saturate, force zero when out of service
    // ------------------------------------------------------------------
    logic signed [17:0] q_raw;
    logic signed [17:0] q_hi;
    logic signed [14:0] q_sat;
    logic signed [14:0] r_o_q;
    logic signed [15:0] r_o_total;
    logic [14:0]        r_o_cap;
    logic signed [15:0] r_o_reac;
    logic [4:0]         r_o_mask;

    always_comb begin
        q_raw = r_p_prod[53:svc_pkg::Q_SHIFT];
        q_hi  = (q_raw > 18'(r_qmax)) ? 18'(r_qmax) : q_raw;
        q_sat = (q_hi < 18'(r_qmin)) ? r_qmin : q_hi[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[ST_O]) begin
            r_o_q     <= r_en ? q_sat : '0;
            r_o_total <= r_en ? r_p_total : '0;
            r_o_cap   <= r_en ? r_p_cap : '0;
            r_o_reac  <= r_en ? r_p_reac : '0;
            r_o_mask  <= r_en ? 5'(r_p_mask) : '0;
        end
    end

    assign o_reactive_power        = r_o_q;
    assign o_total_susceptance     = r_o_total;
    assign o_capacitor_susceptance = r_o_cap;
    assign o_reactor_susceptance   = r_o_reac;
    assign o_step_mask             = r_o_mask;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SVC_ASSERT_NEXT(a_accept_fills_first, i_in_valid && o_in_ready, r_vld[ST_A], "accepted transaction missing from first stage")
    `SVC_ASSERT_HOLDS(a_ready_only_on_full_stall, !o_in_ready |-> (o_out_valid && !i_out_ready), "input blocked with room in the pipeline")
    `SVC_ASSERT_HOLDS(a_total_is_sum, o_out_valid |-> (o_total_susceptance == 16'(o_capacitor_susceptance) + o_reactor_susceptance), "total differs from capacitor plus reactor")
    `SVC_ASSERT_HOLDS(a_reactor_not_capacitive, o_out_valid |-> (o_reactor_susceptance <= 16'sd0 && o_reactor_susceptance >= r_tmin), "reactor susceptance outside its range")
    `SVC_ASSERT_HOLDS(a_q_in_limits, (o_out_valid && r_en && r_qmin <= r_qmax) |-> (o_reactive_power >= r_qmin && o_reactive_power <= r_qmax), "reactive power outside limits")
    `SVC_ASSERT_HOLDS(a_mask_width, o_out_valid |-> ((o_step_mask >> NUM_STEPS) == 5'd0), "step mask bit set beyond the step count")

endmodule

// File: bench/tb_svc_susceptance_dispatch.sv
`timescale 1ns / 1ps

module tb_svc_susceptance_dispatch;

    localparam int NUM_STEPS      = 5;
    localparam int STEP_WIDTH     = 12;
    localparam int CFG_WIDTH      = NUM_STEPS * STEP_WIDTH;
    localparam int LATENCY        = NUM_STEPS + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int N_DIRECTED     = 32;

    // one dispatch decision as it leaves the block
    typedef struct packed {
        logic signed [14:0] reactive_power;
        logic signed [15:0] total_susceptance;
        logic        [14:0] capacitor_susceptance;
        logic signed [15:0] reactor_susceptance;
        logic        [4:0]  step_mask;
    } t_dispatch;

    localparam t_dispatch DISPATCH_ZERO = '0;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_WRITE} t_row_kind;

    // voltage or register data in value, typed result only for ROW_TYPED
    typedef struct packed {
        t_row_kind              kind;
        svc_pkg::t_cfg_index    index;
        logic [CFG_WIDTH-1:0]   value;
        t_dispatch              result;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    svc_pkg::t_cfg_index    i_cfg_index = svc_pkg::CFG_ENABLE;
    logic [CFG_WIDTH-1:0]   i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [14:0]            i_measured_voltage = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [14:0]     o_reactive_power;
    logic signed [15:0]     o_total_susceptance;
    logic [14:0]            o_capacitor_susceptance;
    logic signed [15:0]     o_reactor_susceptance;
    logic [4:0]             o_step_mask;

    // mirror of the block's register file
    logic                   cfg_enable = svc_pkg::ENABLE_RST;
    logic        [14:0]     cfg_vref   = svc_pkg::VREF_RST;
    logic        [15:0]     cfg_gain   = svc_pkg::GAIN_RST;
    logic signed [15:0]     cfg_tmin   = svc_pkg::TMIN_RST;
    logic signed [14:0]     cfg_qmin   = svc_pkg::QMIN_RST;
    logic signed [14:0]     cfg_qmax   = svc_pkg::QMAX_RST;
    logic [CFG_WIDTH-1:0]   cfg_table  = svc_pkg::TABLE_RST;

    t_dispatch expected_dispatch [$];
    int        dispatch_errors = 0;
    int        idle_cycles = 0;
    bit        send_calm = 1'b0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        // right after reset: on target, far below, far above
        '{ROW_TYPED, svc_pkg::CFG_ENABLE, 60'd16384, DISPATCH_ZERO},
        '{ROW_TYPED, svc_pkg::CFG_ENABLE, 60'd0,
          '{15'sd0, 16'sd2050, 15'd2050, 16'sd0, 5'd31}},
        '{ROW_TYPED, svc_pkg::CFG_ENABLE, 60'd32767,
          '{-15'sd160, -16'sd410, 15'd0, -16'sd410, 5'd0}},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd16000, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd16900, DISPATCH_ZERO},
        // out of service forces zeros
        '{ROW_WRITE, svc_pkg::CFG_ENABLE, 60'd0, DISPATCH_ZERO},
        '{ROW_TYPED, svc_pkg::CFG_ENABLE, 60'd0, DISPATCH_ZERO},
        '{ROW_TYPED, svc_pkg::CFG_ENABLE, 60'd32767, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_ENABLE, 60'd1, DISPATCH_ZERO},
        // zero step, tied steps, full-scale step
        '{ROW_WRITE, svc_pkg::CFG_TABLE,
          {12'd2048, 12'd1000, 12'd1000, 12'd4095, 12'd0}, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_QMIN, 60'h4000, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_QMAX, 60'h3FFF, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_GAIN, 60'hFFFF, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd0, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd16384, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd16200, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd32767, DISPATCH_ZERO},
        // deepest reactor limit, then a positive one
        '{ROW_WRITE, svc_pkg::CFG_TMIN, 60'h8000, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd32767, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_TMIN, 60'h7FFF, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd20000, DISPATCH_ZERO},
        // crossed limits: qmin 1000 above qmax -1000
        '{ROW_WRITE, svc_pkg::CFG_QMIN, 60'd1000, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_QMAX, 60'h7C18, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd16384, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd0, DISPATCH_ZERO},
        // reference extremes and zero gain
        '{ROW_WRITE, svc_pkg::CFG_VREF, 60'd0, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd1, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_VREF, 60'd32767, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd32767, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd12345, DISPATCH_ZERO},
        '{ROW_WRITE, svc_pkg::CFG_GAIN, 60'd0, DISPATCH_ZERO},
        '{ROW_ITEM,  svc_pkg::CFG_ENABLE, 60'd5000, DISPATCH_ZERO}
    };

    svc_susceptance_dispatch #(
        .NUM_STEPS  (NUM_STEPS),
        .STEP_WIDTH (STEP_WIDTH)
    ) dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_measured_voltage      (i_measured_voltage),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_reactive_power        (o_reactive_power),
        .o_total_susceptance     (o_total_susceptance),
        .o_capacitor_susceptance (o_capacitor_susceptance),
        .o_reactor_susceptance   (o_reactor_susceptance),
        .o_step_mask             (o_step_mask)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // division rounding toward minus infinity, positive divisor
    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    // regulated susceptance, greedy step fit, reactor residual, saturated q
    function automatic t_dispatch predict_dispatch(logic [14:0] volt);
        t_dispatch r;
        longint    v, qlo, qhi, blo, bhi, bref, need, cap, reac, total, q, rmin;
        longint    step_val [NUM_STEPS];
        bit [NUM_STEPS-1:0] taken;
        logic [4:0] mask;
        int        best;
        r = DISPATCH_ZERO;
        if (!cfg_enable) return r;
        v    = longint'(volt);
        qlo  = longint'(cfg_qmin);
        qhi  = longint'(cfg_qmax);
        bref = floor_div(longint'(cfg_gain) * (longint'(cfg_vref) - v), 1024);
        blo  = floor_div(qlo * 256, 100);
        bhi  = floor_div(qhi * 256, 100);
        // upper bound first, so the lower one wins when crossed
        if (bref > bhi) bref = bhi;
        if (bref < blo) bref = blo;
        for (int i = 0; i < NUM_STEPS; i++)
            step_val[i] = longint'(cfg_table[i*STEP_WIDTH +: STEP_WIDTH]);
        taken = '0;
        mask  = '0;
        cap   = 0;
        need  = (bref > 0) ? bref : 0;
        // largest first, ties to the lower index
        for (int k = 0; k < NUM_STEPS; k++) begin
            best = -1;
            for (int i = 0; i < NUM_STEPS; i++)
                if (!taken[i] && (best < 0 || step_val[i] > step_val[best])) best = i;
            taken[best] = 1'b1;
            if (cap + step_val[best] <= need) begin
                cap = cap + step_val[best];
                mask[best] = 1'b1;
            end
        end
        // reactor never goes capacitive
        rmin = longint'(cfg_tmin);
        if (rmin > 0) rmin = 0;
        reac = 0;
        if (bref - cap < 0) begin
            reac = bref - cap;
            if (reac < rmin) reac = rmin;
        end
        total = cap + reac;
        q = floor_div(total * v * v * 100, longint'(1) << 36);
        if (q > qhi) q = qhi;
        if (q < qlo) q = qlo;
        r.reactive_power        = q[14:0];
        r.total_susceptance     = total[15:0];
        r.capacitor_susceptance = cap[14:0];
        r.reactor_susceptance   = reac[15:0];
        r.step_mask             = mask;
        return r;
    endfunction

    // one register write, mirrored for the predictor
    task automatic write_register(input svc_pkg::t_cfg_index idx,
                                  input logic [CFG_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            svc_pkg::CFG_ENABLE: cfg_enable = data[0];
            svc_pkg::CFG_VREF:   cfg_vref   = data[14:0];
            svc_pkg::CFG_GAIN:   cfg_gain   = data[15:0];
            svc_pkg::CFG_TMIN:   cfg_tmin   = data[15:0];
            svc_pkg::CFG_QMIN:   cfg_qmin   = data[14:0];
            svc_pkg::CFG_QMAX:   cfg_qmax   = data[14:0];
            svc_pkg::CFG_TABLE:  cfg_table  = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drop valid and wait until every expected result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_dispatch.size() != 0) @(posedge i_clk);
    endtask

    // offer one voltage sample, record its expected decision on acceptance
    task automatic send_voltage(input logic [14:0] volt, input t_dispatch want);
        int gap;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_measured_voltage <= volt;
        do @(posedge i_clk); while (!o_in_ready);
        expected_dispatch.push_back(want);
    endtask

    // random register settings, extremes included
    task automatic randomize_settings();
        logic [14:0]          vref, qmin, qmax;
        logic [15:0]          gain, tmin;
        logic [CFG_WIDTH-1:0] steps;
        int                   lo, hi;
        write_register(svc_pkg::CFG_ENABLE, ($urandom_range(0, 7) == 0) ? 60'd0 : 60'd1);
        case ($urandom_range(0, 5))
            0:       vref = 15'd0;
            1:       vref = 15'h7FFF;
            2:       vref = 15'($urandom);
            default: vref = 15'(16384 - 2048 + int'($urandom_range(0, 4096)));
        endcase
        write_register(svc_pkg::CFG_VREF, CFG_WIDTH'(vref));
        case ($urandom_range(0, 5))
            0:       gain = 16'd0;
            1:       gain = 16'hFFFF;
            2:       gain = 16'(25600 + int'($urandom_range(0, 8192)) - 4096);
            default: gain = 16'($urandom);
        endcase
        write_register(svc_pkg::CFG_GAIN, CFG_WIDTH'(gain));
        case ($urandom_range(0, 5))
            0:       tmin = 16'd0;
            1:       tmin = 16'h8000;
            2:       tmin = 16'($urandom_range(1, 32767));
            default: tmin = 16'(-int'($urandom_range(0, 8192)));
        endcase
        write_register(svc_pkg::CFG_TMIN, CFG_WIDTH'(tmin));
        case ($urandom_range(0, 5))
            0: begin
                // crossed limits
                lo = int'($urandom_range(0, 16383));
                hi = -int'($urandom_range(0, 16384));
            end
            1: begin
                lo = -16384;
                hi = 16383;
            end
            2: begin
                lo = int'($urandom_range(0, 32767)) - 16384;
                hi = int'($urandom_range(0, 32767)) - 16384;
            end
            default: begin
                lo = -int'($urandom_range(0, 2000));
                hi = int'($urandom_range(0, 4000));
            end
        endcase
        qmin = 15'(lo);
        qmax = 15'(hi);
        write_register(svc_pkg::CFG_QMIN, CFG_WIDTH'(qmin));
        write_register(svc_pkg::CFG_QMAX, CFG_WIDTH'(qmax));
        // zero steps, full-scale steps and repeats of the previous step
        steps = '0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            case ($urandom_range(0, 7))
                0:       steps[i*STEP_WIDTH +: STEP_WIDTH] = '0;
                1:       steps[i*STEP_WIDTH +: STEP_WIDTH] = '1;
                2:       steps[i*STEP_WIDTH +: STEP_WIDTH] = (i == 0) ? 12'd410 :
                             steps[(i-1)*STEP_WIDTH +: STEP_WIDTH];
                3:       steps[i*STEP_WIDTH +: STEP_WIDTH] = 12'($urandom_range(1, 600));
                default: steps[i*STEP_WIDTH +: STEP_WIDTH] = 12'($urandom);
            endcase
        end
        write_register(svc_pkg::CFG_TABLE, steps);
    endtask

    // stimulus: directed table, then random phases
    initial begin
        int span, vv;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            case (directed_rows[n].kind)
                ROW_WRITE: begin
                    settle();
                    write_register(directed_rows[n].index, directed_rows[n].value);
                end
                ROW_TYPED: send_voltage(directed_rows[n].value[14:0], directed_rows[n].result);
                default:   send_voltage(directed_rows[n].value[14:0],
                                        predict_dispatch(directed_rows[n].value[14:0]));
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            randomize_settings();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    // near the target, where the reference is not pinned
                    span = int'($urandom_range(1, 4096));
                    vv = int'(cfg_vref) - span + int'($urandom_range(0, 2 * span));
                    if (vv < 0) vv = 0;
                    if (vv > 32767) vv = 32767;
                end else begin
                    vv = int'($urandom_range(0, 32767));
                end
                send_voltage(15'(vv), predict_dispatch(15'(vv)));
            end
        end

        settle();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (dispatch_errors == 0 && expected_dispatch.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random stalls with calm stretches
    initial begin
        int stall;
        bit calm;
        calm = 1'b0;
        forever begin
            if ($urandom_range(0, 31) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_dispatch got, want;
        bit        bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_reactive_power, o_total_susceptance, o_capacitor_susceptance,
                    o_reactor_susceptance, o_step_mask};
            if (expected_dispatch.size() == 0) begin
                bad  = 1'b1;
                want = DISPATCH_ZERO;
            end else begin
                want = expected_dispatch.pop_front();
                bad  = (got.reactive_power !== want.reactive_power) ||
                       (got.total_susceptance !== want.total_susceptance) ||
                       (got.capacitor_susceptance !== want.capacitor_susceptance) ||
                       (got.reactor_susceptance !== want.reactor_susceptance) ||
                       (got.step_mask !== want.step_mask);
            end
            if (bad) begin
                dispatch_errors <= dispatch_errors + 1;
                if (dispatch_errors < 10)
                    $display("mismatch at %0t (%s): exp q=%0d bt=%0d bc=%0d br=%0d m=%b",
                             $realtime,
                             (expected_dispatch.size() == 0 && want == DISPATCH_ZERO) ?
                                 "maybe unexpected" : "field",
                             want.reactive_power, want.total_susceptance,
                             want.capacitor_susceptance, want.reactor_susceptance,
                             want.step_mask,
                             "\n    got q=%0d bt=%0d bc=%0d br=%0d m=%b",
                             got.reactive_power, got.total_susceptance,
                             got.capacitor_susceptance, got.reactor_susceptance,
                             got.step_mask);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: filelist.f
+incdir+sv
sv/svc_pkg.sv
sv/svc_susceptance_dispatch.sv
bench/tb_svc_susceptance_dispatch.sv
